FILE: design/pgfc_pkg.sv
// Package: shared types, constants and register indexes for the PPS gated frequency counter.
package pgfc_pkg;

  localparam int TIME_BITS       = 48;
  localparam int GATE_COUNT_BITS = 40;
  localparam int SEC_BITS        = 25;
  localparam int ERR_BITS        = 32;
  localparam int WIN_BITS        = 24;
  localparam int LOCK_BITS       = 4;
  localparam int GATE_SEC_BITS   = 16;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CMD_FIFO_DEPTH  = 2;

  // Request codes
  localparam logic [2:0] REQ_PPS     = 3'd0;
  localparam logic [2:0] REQ_WDOG    = 3'd1;
  localparam logic [2:0] REQ_SETTLE  = 3'd2;
  localparam logic [2:0] REQ_START   = 3'd3;
  localparam logic [2:0] REQ_RST_ERR = 3'd4;

  // Report codes
  localparam logic [1:0] REP_NONE   = 2'd0;
  localparam logic [1:0] REP_SECOND = 2'd1;
  localparam logic [1:0] REP_LONG   = 2'd2;

  // Status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_HIGH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCK_PULSES = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_SEC    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NOMINAL     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LATE_LIMIT  = 3'd5;

  // Register reset values
  localparam logic [WIN_BITS-1:0]      RST_WINDOW_LOW  = 24'd800000;
  localparam logic [WIN_BITS-1:0]      RST_WINDOW_HIGH = 24'd1200000;
  localparam logic [LOCK_BITS-1:0]     RST_LOCK_PULSES = 4'd8;
  localparam logic [GATE_SEC_BITS-1:0] RST_GATE_SEC    = 16'd1;
  localparam logic [SEC_BITS-1:0]      RST_NOMINAL     = 25'd10000000;
  localparam logic [WIN_BITS-1:0]      RST_LATE_LIMIT  = 24'd500000;

  typedef struct packed {
    logic [WIN_BITS-1:0]      window_low_us;
    logic [WIN_BITS-1:0]      window_high_us;
    logic [LOCK_BITS-1:0]     lock_pulses;
    logic [GATE_SEC_BITS-1:0] gate_seconds;
    logic [SEC_BITS-1:0]      nominal_count;
    logic [WIN_BITS-1:0]      late_limit_us;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                 req_type;
    logic [TIME_BITS-1:0]       time_us;
    logic [SEC_BITS-1:0]        second_count;
    logic [GATE_COUNT_BITS-1:0] long_gate_count;
  } req_t;

  typedef struct packed {
    logic [3:0]                 seq_state;
    logic                       locked;
    logic                       gate_arm;
    logic                       clear_counters;
    logic [1:0]                 report;
    logic signed [ERR_BITS-1:0] error_ticks;
    logic [ERR_BITS-1:0]        error_seconds;
    logic [GATE_COUNT_BITS-1:0] cumulative_count;
    logic                       status;
  } rsp_t;

  // Classified command passed from the front end to the sequencer
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PPS,
    CMD_LOSS,
    CMD_SETTLE,
    CMD_START,
    CMD_RST_ERR,
    CMD_BAD
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic                       locked;
    logic                       late;
    logic [SEC_BITS-1:0]        second_count;
    logic [ERR_BITS-1:0]        second_err;
    logic [GATE_COUNT_BITS-1:0] long_gate_count;
  } cmd_t;

endpackage

FILE: design/pgfc_if.sv
// Interfaces: request, response and configuration channels.
interface pgfc_req_if import pgfc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pgfc_rsp_if import pgfc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pgfc_cfg_if import pgfc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  idx;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

FILE: design/pgfc_front.sv
// Front end: PPS qualification, lock bookkeeping and request classification.
module pgfc_front import pgfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  req_valid_i,
  input  req_t  req_i,
  input  logic  push_ready_i,
  output logic  req_ready_o,
  output logic  push_valid_o,
  output cmd_t  cmd_o
);

  logic [TIME_BITS-1:0] last_pps_q, last_pps_d;
  logic [LOCK_BITS-1:0] good_q, good_d;
  logic                 locked_q, locked_d;
  logic [TIME_BITS-1:0] diff;
  logic                 in_window;
  logic                 fire;

  assign req_ready_o  = push_ready_i;
  assign push_valid_o = req_valid_i;
  assign fire         = req_valid_i && push_ready_i;

  assign diff      = req_i.time_us - last_pps_q;
  assign in_window = (diff > TIME_BITS'(cfg_i.window_low_us)) &&
                     (diff < TIME_BITS'(cfg_i.window_high_us));

  always_comb begin
    last_pps_d = last_pps_q;
    good_d     = good_q;
    locked_d   = locked_q;
    cmd_o.kind = CMD_NONE;
    cmd_o.late = diff > TIME_BITS'(cfg_i.late_limit_us);
    cmd_o.second_count    = req_i.second_count;
    cmd_o.long_gate_count = req_i.long_gate_count;
    cmd_o.second_err = ERR_BITS'(req_i.second_count) - ERR_BITS'(cfg_i.nominal_count);
    unique case (req_i.req_type)
      REQ_PPS: begin
        last_pps_d = req_i.time_us;
        if (good_q == '0 || in_window) begin
          if (good_q < cfg_i.lock_pulses) begin
            good_d = good_q + 1'b1;
          end else begin
            locked_d   = 1'b1;
            cmd_o.kind = CMD_PPS;
          end
        end else begin
          good_d = '0;
          if (locked_q) begin
            locked_d   = 1'b0;
            cmd_o.kind = CMD_LOSS;
          end
        end
      end
      REQ_WDOG: begin
        good_d = '0;
        if (locked_q) begin
          locked_d   = 1'b0;
          cmd_o.kind = CMD_LOSS;
        end
      end
      REQ_SETTLE:  cmd_o.kind = CMD_SETTLE;
      REQ_START:   cmd_o.kind = CMD_START;
      REQ_RST_ERR: cmd_o.kind = CMD_RST_ERR;
      default:     cmd_o.kind = CMD_BAD;
    endcase
    cmd_o.locked = locked_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pps_q <= '0;
      good_q     <= '0;
      locked_q   <= 1'b0;
    end else if (fire) begin
      last_pps_q <= last_pps_d;
      good_q     <= good_d;
      locked_q   <= locked_d;
    end
  end

endmodule

FILE: design/pgfc_fifo.sv
// Command queue between the front end and the sequencer.
module pgfc_fifo import pgfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam int PtrW = $clog2(CMD_FIFO_DEPTH);
  localparam int CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            mem_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(CMD_FIFO_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: design/pgfc_back.sv
// Back end: gate sequencer, error accumulation and response register.
module pgfc_back import pgfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_ready_o,
  pgfc_rsp_if.source rsp_o
);

  typedef enum logic [3:0] {
    ST_STARTUP     = 4'd0,
    ST_WAIT_BEFORE = 4'd1,
    ST_PAST_BEFORE = 4'd2,
    ST_WAIT_FIRST  = 4'd3,
    ST_PAST_FIRST  = 4'd4,
    ST_WAIT_NEXT   = 4'd5,
    ST_PAST_NEXT   = 4'd6,
    ST_WAIT_LAST   = 4'd7,
    ST_PAST_LAST   = 4'd8
  } seq_state_e;

  seq_state_e                 state_q, state_d;
  logic [GATE_SEC_BITS-1:0]   left_q, left_d;
  logic                       gate_q, gate_d;
  logic [ERR_BITS-1:0]        err_q, err_d;
  logic [ERR_BITS-1:0]        dur_q, dur_d;
  logic [GATE_COUNT_BITS-1:0] cum_q, cum_d, cum_sum, cum_out;
  logic                       clr, status;
  logic [1:0]                 rep;
  logic                       out_valid_q;
  rsp_t                       out_q;
  logic                       take;

  assign cmd_ready_o = !out_valid_q || rsp_o.ready;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign cum_sum     = cum_q + GATE_COUNT_BITS'(cmd_i.second_count);

  always_comb begin
    state_d = state_q;
    left_d  = left_q;
    gate_d  = gate_q;
    err_d   = err_q;
    dur_d   = dur_q;
    cum_d   = cum_q;
    clr     = 1'b0;
    rep     = REP_NONE;
    status  = STATUS_OK;
    cum_out = cum_q;
    unique case (cmd_i.kind)
      CMD_PPS, CMD_LOSS: begin
        if (state_q == ST_STARTUP || state_q > ST_PAST_LAST) begin
          status = STATUS_REJECTED;
        end else if (cmd_i.kind == CMD_LOSS || !state_q[0]) begin
          gate_d  = 1'b0;
          state_d = ST_WAIT_BEFORE;
        end else begin
          state_d = seq_state_e'(state_q + 4'd1);
        end
      end
      CMD_SETTLE: begin
        if (state_q != ST_PAST_BEFORE && state_q != ST_PAST_FIRST &&
            state_q != ST_PAST_NEXT && state_q != ST_PAST_LAST) begin
          status = STATUS_REJECTED;
        end else if (cmd_i.late) begin
          gate_d  = 1'b0;
          state_d = ST_WAIT_BEFORE;
        end else if (state_q == ST_PAST_BEFORE) begin
          clr     = 1'b1;
          gate_d  = 1'b0;
          state_d = ST_WAIT_FIRST;
        end else if (state_q == ST_PAST_FIRST) begin
          clr     = 1'b1;
          cum_d   = '0;
          dur_d   = '0;
          err_d   = '0;
          left_d  = (cfg_i.gate_seconds == '0) ? GATE_SEC_BITS'(1) : cfg_i.gate_seconds;
          gate_d  = 1'b1;
          state_d = ST_WAIT_NEXT;
        end else if (state_q == ST_PAST_NEXT) begin
          rep   = REP_SECOND;
          dur_d = dur_q + 1'b1;
          err_d = err_q + cmd_i.second_err;
          if (left_q < cfg_i.gate_seconds) begin
            cum_d = cum_sum;
          end
          left_d = left_q - 1'b1;
          if (left_q == GATE_SEC_BITS'(1)) begin
            gate_d  = 1'b0;
            state_d = ST_WAIT_LAST;
          end else begin
            state_d = ST_WAIT_NEXT;
          end
        end else begin
          // long gate done: correct error by the long count, restart the gate
          rep     = REP_LONG;
          err_d   = err_q + cmd_i.long_gate_count[ERR_BITS-1:0] - cum_sum[ERR_BITS-1:0];
          cum_d   = '0;
          left_d  = (cfg_i.gate_seconds == '0) ? GATE_SEC_BITS'(1) : cfg_i.gate_seconds;
          gate_d  = 1'b1;
          state_d = ST_WAIT_NEXT;
        end
      end
      CMD_START: begin
        if (state_q == ST_STARTUP) begin
          gate_d  = 1'b0;
          state_d = ST_WAIT_FIRST;
        end else begin
          status = STATUS_REJECTED;
        end
      end
      CMD_RST_ERR: begin
        err_d = '0;
        dur_d = '0;
      end
      CMD_BAD:  status = STATUS_REJECTED;
      default: ;
    endcase
    cum_out = (rep == REP_LONG) ? cum_sum : cum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_STARTUP;
      left_q      <= '0;
      gate_q      <= 1'b0;
      err_q       <= '0;
      dur_q       <= '0;
      cum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        state_q     <= state_d;
        left_q      <= left_d;
        gate_q      <= gate_d;
        err_q       <= err_d;
        dur_q       <= dur_d;
        cum_q       <= cum_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.seq_state        <= state_d;
      out_q.locked           <= cmd_i.locked;
      out_q.gate_arm         <= gate_d;
      out_q.clear_counters   <= clr;
      out_q.report           <= rep;
      out_q.error_ticks      <= err_d;
      out_q.error_seconds    <= dur_d;
      out_q.cumulative_count <= cum_out;
      out_q.status           <= status;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

FILE: design/pps_gated_frequency_counter_unit.sv
// Top level: PPS gated frequency counter with configuration registers.
// Path: the front end classifies a request in its accept cycle, the command queue
//   registers the command, and the sequencer registers the response.
// Throughput: one transaction per cycle unless stalled; a 2-entry command queue decouples the
//   front end from the response register so either side may stall.
// Reset (rst_ni, async low): registers take their default values, lock and
//   sequencer state clear, the queue empties.
module pps_gated_frequency_counter_unit import pgfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pgfc_cfg_if.sink  cfg_i,
  pgfc_req_if.sink  req_i,
  pgfc_rsp_if.source rsp_o
);

  // sequencer state codes as seen on the response
  localparam logic [3:0] SEQ_WAIT_FIRST = 4'd3;
  localparam logic [3:0] SEQ_WAIT_NEXT  = 4'd5;
  localparam logic [3:0] SEQ_WAIT_LAST  = 4'd7;

  cfg_t cfg_q;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // Configuration registers; writes are always taken, unknown indexes ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low_us  <= RST_WINDOW_LOW;
      cfg_q.window_high_us <= RST_WINDOW_HIGH;
      cfg_q.lock_pulses    <= RST_LOCK_PULSES;
      cfg_q.gate_seconds   <= RST_GATE_SEC;
      cfg_q.nominal_count  <= RST_NOMINAL;
      cfg_q.late_limit_us  <= RST_LATE_LIMIT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        CFG_WINDOW_LOW:  cfg_q.window_low_us  <= cfg_i.data[WIN_BITS-1:0];
        CFG_WINDOW_HIGH: cfg_q.window_high_us <= cfg_i.data[WIN_BITS-1:0];
        CFG_LOCK_PULSES: cfg_q.lock_pulses    <= cfg_i.data[LOCK_BITS-1:0];
        CFG_GATE_SEC:    cfg_q.gate_seconds   <= cfg_i.data[GATE_SEC_BITS-1:0];
        CFG_NOMINAL:     cfg_q.nominal_count  <= cfg_i.data[SEC_BITS-1:0];
        CFG_LATE_LIMIT:  cfg_q.late_limit_us  <= cfg_i.data[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end: owns PPS timing and lock; emits one command per transaction.
  pgfc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .req_valid_i  (req_i.valid),
    .req_i        (req_i.data),
    .push_ready_i (push_ready),
    .req_ready_o  (req_i.ready),
    .push_valid_o (push_valid),
    .cmd_o        (push_cmd)
  );

  pgfc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  // Back end: sequencer and accumulators, registered response.
  pgfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .rsp_o       (rsp_o)
  );

  // A rejected transaction never clears counters or reports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.status |->
      !rsp_o.data.clear_counters && rsp_o.data.report == REP_NONE)
    else $error("rejected transaction had side effects");

  // Long-gate report restarts the gate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.report == REP_LONG |->
      rsp_o.data.gate_arm && rsp_o.data.seq_state == SEQ_WAIT_NEXT)
    else $error("long report without gate restart");

  // Counter clear only happens when moving into a waiting state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.clear_counters |->
      rsp_o.data.seq_state == SEQ_WAIT_FIRST || rsp_o.data.seq_state == SEQ_WAIT_NEXT)
    else $error("clear outside gate setup");

  // A per-second report lands in the next-pps or last-pps wait state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.report == REP_SECOND |->
      rsp_o.data.seq_state == SEQ_WAIT_NEXT || rsp_o.data.seq_state == SEQ_WAIT_LAST)
    else $error("per-second report in wrong state");

endmodule

FILE: tb/pgfc_report_monitor.sv
// Response monitor: predicts every counter response and compares it with the DUT output.
`timescale 1ns / 1ps
module pgfc_report_monitor import pgfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pgfc_cfg_if  cfg_i,
  pgfc_req_if  req_i,
  pgfc_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  // sequencer states, dense numbering
  localparam logic [3:0] SEQ_STARTUP    = 4'd0;
  localparam logic [3:0] SEQ_WAIT_PRE   = 4'd1;
  localparam logic [3:0] SEQ_PAST_PRE   = 4'd2;
  localparam logic [3:0] SEQ_WAIT_FIRST = 4'd3;
  localparam logic [3:0] SEQ_PAST_FIRST = 4'd4;
  localparam logic [3:0] SEQ_WAIT_NEXT  = 4'd5;
  localparam logic [3:0] SEQ_PAST_NEXT  = 4'd6;
  localparam logic [3:0] SEQ_WAIT_LAST  = 4'd7;
  localparam logic [3:0] SEQ_PAST_LAST  = 4'd8;

  cfg_t                       shadow_cfg;
  logic [TIME_BITS-1:0]       last_pps;
  logic [LOCK_BITS-1:0]       good_cnt;
  logic                       pps_lock;
  logic [3:0]                 seq;
  logic [GATE_SEC_BITS-1:0]   secs_left;
  logic                       gate_lvl;
  logic [ERR_BITS-1:0]        err_acc;
  logic [ERR_BITS-1:0]        err_dur;
  logic [GATE_COUNT_BITS-1:0] cum_acc;

  rsp_t pending_reports[$];
  int   fails = 0;
  int   depth = 0;

  assign fail_count_o = fails;
  assign pending_o    = depth;

  task automatic clear_model();
    shadow_cfg.window_low_us  = RST_WINDOW_LOW;
    shadow_cfg.window_high_us = RST_WINDOW_HIGH;
    shadow_cfg.lock_pulses    = RST_LOCK_PULSES;
    shadow_cfg.gate_seconds   = RST_GATE_SEC;
    shadow_cfg.nominal_count  = RST_NOMINAL;
    shadow_cfg.late_limit_us  = RST_LATE_LIMIT;
    last_pps  = '0;
    good_cnt  = '0;
    pps_lock  = 1'b0;
    seq       = SEQ_STARTUP;
    secs_left = '0;
    gate_lvl  = 1'b0;
    err_acc   = '0;
    err_dur   = '0;
    cum_acc   = '0;
  endtask

  function automatic void load_gate();
    secs_left = (shadow_cfg.gate_seconds == '0) ? GATE_SEC_BITS'(1) : shadow_cfg.gate_seconds;
    gate_lvl  = 1'b1;
  endfunction

  function automatic void drop_gate();
    gate_lvl = 1'b0;
    seq      = SEQ_WAIT_PRE;
  endfunction

  // pps (lost = 0) or loss (lost = 1) seen by the sequencer; 1 when taken
  function automatic bit sequencer_edge(bit lost);
    if (seq == SEQ_STARTUP || seq > SEQ_PAST_LAST) return 1'b0;
    if (lost || !seq[0]) begin
      drop_gate();
      return 1'b1;
    end
    seq = seq + 4'd1;
    return 1'b1;
  endfunction

  function automatic rsp_t step_counter(req_t rq);
    rsp_t                       r;
    logic [TIME_BITS-1:0]       diff;
    logic [GATE_COUNT_BITS-1:0] lg_diff;
    logic [GATE_COUNT_BITS-1:0] cum_out;
    logic                       clr;
    logic [1:0]                 rep;
    logic                       st;
    clr  = 1'b0;
    rep  = REP_NONE;
    st   = STATUS_OK;
    diff = rq.time_us - last_pps;
    case (rq.req_type)
      REQ_PPS: begin
        last_pps = rq.time_us;
        if (good_cnt == '0 || (diff > TIME_BITS'(shadow_cfg.window_low_us) &&
                               diff < TIME_BITS'(shadow_cfg.window_high_us))) begin
          if (good_cnt < shadow_cfg.lock_pulses) begin
            good_cnt = good_cnt + LOCK_BITS'(1);
          end else begin
            pps_lock = 1'b1;
            if (!sequencer_edge(1'b0)) st = STATUS_REJECTED;
          end
        end else begin
          good_cnt = '0;
          if (pps_lock) begin
            pps_lock = 1'b0;
            if (!sequencer_edge(1'b1)) st = STATUS_REJECTED;
          end
        end
      end
      REQ_WDOG: begin
        good_cnt = '0;
        if (pps_lock) begin
          pps_lock = 1'b0;
          if (!sequencer_edge(1'b1)) st = STATUS_REJECTED;
        end
      end
      REQ_SETTLE: begin
        if (seq != SEQ_PAST_PRE && seq != SEQ_PAST_FIRST &&
            seq != SEQ_PAST_NEXT && seq != SEQ_PAST_LAST) begin
          st = STATUS_REJECTED;
        end else if (diff > TIME_BITS'(shadow_cfg.late_limit_us)) begin
          drop_gate();
        end else if (seq == SEQ_PAST_PRE) begin
          clr      = 1'b1;
          gate_lvl = 1'b0;
          seq      = SEQ_WAIT_FIRST;
        end else if (seq == SEQ_PAST_FIRST) begin
          clr     = 1'b1;
          cum_acc = '0;
          err_dur = '0;
          err_acc = '0;
          load_gate();
          seq     = SEQ_WAIT_NEXT;
        end else if (seq == SEQ_PAST_NEXT) begin
          rep     = REP_SECOND;
          err_dur = err_dur + ERR_BITS'(1);
          err_acc = err_acc + (ERR_BITS'(rq.second_count) -
                               ERR_BITS'(shadow_cfg.nominal_count));
          if (secs_left < shadow_cfg.gate_seconds)
            cum_acc = cum_acc + GATE_COUNT_BITS'(rq.second_count);
          secs_left = secs_left - GATE_SEC_BITS'(1);
          if (secs_left == '0) begin
            gate_lvl = 1'b0;
            seq      = SEQ_WAIT_LAST;
          end else begin
            seq = SEQ_WAIT_NEXT;
          end
        end else begin
          rep     = REP_LONG;
          cum_acc = cum_acc + GATE_COUNT_BITS'(rq.second_count);
          lg_diff = rq.long_gate_count - cum_acc;
          err_acc = err_acc + lg_diff[ERR_BITS-1:0];
        end
      end
      REQ_START: begin
        if (seq == SEQ_STARTUP) begin
          gate_lvl = 1'b0;
          seq      = SEQ_WAIT_FIRST;
        end else begin
          st = STATUS_REJECTED;
        end
      end
      REQ_RST_ERR: begin
        err_acc = '0;
        err_dur = '0;
      end
      default: st = STATUS_REJECTED;
    endcase

    // long-gate report shows the sum, then restarts the gate
    cum_out = cum_acc;
    if (rep == REP_LONG) begin
      cum_acc = '0;
      load_gate();
      seq = SEQ_WAIT_NEXT;
    end

    r.seq_state        = seq;
    r.locked           = pps_lock;
    r.gate_arm         = gate_lvl;
    r.clear_counters   = clr;
    r.report           = rep;
    r.error_ticks      = $signed(err_acc);
    r.error_seconds    = err_dur;
    r.cumulative_count = cum_out;
    r.status           = st;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      clear_model();
      pending_reports.delete();
      depth = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.idx)
          CFG_WINDOW_LOW:  shadow_cfg.window_low_us  = cfg_i.data[WIN_BITS-1:0];
          CFG_WINDOW_HIGH: shadow_cfg.window_high_us = cfg_i.data[WIN_BITS-1:0];
          CFG_LOCK_PULSES: shadow_cfg.lock_pulses    = cfg_i.data[LOCK_BITS-1:0];
          CFG_GATE_SEC:    shadow_cfg.gate_seconds   = cfg_i.data[GATE_SEC_BITS-1:0];
          CFG_NOMINAL:     shadow_cfg.nominal_count  = cfg_i.data[SEC_BITS-1:0];
          CFG_LATE_LIMIT:  shadow_cfg.late_limit_us  = cfg_i.data[WIN_BITS-1:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) pending_reports.push_back(step_counter(req_i.data));
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: response with none outstanding, expected none actual %h",
                   $time, rsp_i.data);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          check_field("seq_state", 64'(want.seq_state), 64'(rsp_i.data.seq_state));
          check_field("locked", 64'(want.locked), 64'(rsp_i.data.locked));
          check_field("gate_arm", 64'(want.gate_arm), 64'(rsp_i.data.gate_arm));
          check_field("clear_counters", 64'(want.clear_counters),
                      64'(rsp_i.data.clear_counters));
          check_field("report", 64'(want.report), 64'(rsp_i.data.report));
          check_field("error_ticks", 64'($unsigned(want.error_ticks)),
                      64'($unsigned(rsp_i.data.error_ticks)));
          check_field("error_seconds", 64'(want.error_seconds),
                      64'(rsp_i.data.error_seconds));
          check_field("cumulative_count", 64'(want.cumulative_count),
                      64'(rsp_i.data.cumulative_count));
          check_field("status", 64'(want.status), 64'(rsp_i.data.status));
        end
      end
      depth = pending_reports.size();
    end
  end

endmodule

FILE: tb/pps_gated_frequency_counter_unit_tb.sv
// Testbench top: clock, reset, stimulus, flow control and verdict for the PPS gated counter.
`timescale 1ns / 1ps
module pps_gated_frequency_counter_unit_tb;
  import pgfc_pkg::*;

  // request codes the block must reject as unknown
  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on any channel
  localparam int HOLD_CYCLES    = 80;    // long response back-pressure stretch
  localparam int DRAIN_CYCLES   = 10;    // settle time at the end, after every response is back

  localparam logic [SEC_BITS-1:0]        SEC_MAX  = '1;
  localparam logic [GATE_COUNT_BITS-1:0] LONG_MAX = '1;
  localparam logic [TIME_BITS-1:0]       TIME_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  pgfc_cfg_if cfg_if ();
  pgfc_req_if req_if ();
  pgfc_rsp_if rsp_if ();

  int fail_count;
  int pending;

  pps_gated_frequency_counter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pgfc_report_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Flow control knobs, written by the stimulus process only.
  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 69;
  int          hold_requests = 0;

  // Receiver-side bookkeeping, owned by the receiver process.
  int holds_done = 0;
  int hold_left  = 0;

  // Stimulus-side view of the programmed registers and of the PPS timeline.
  cfg_t                 cfg_now;
  logic [TIME_BITS-1:0] pps_t;
  int                   sent_items = 0;
  int                   idle_cycles = 0;

  // ------------------------------------------------------------------------
  // Watchdog: a run that stops moving is a failure.
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Response side: random ready, plus a counted hold-off on request so the
  // command queue fills and the block has to stall its request port.
  // ------------------------------------------------------------------------
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  function automatic req_t make_req(logic [2:0] kind, logic [TIME_BITS-1:0] t,
                                    logic [SEC_BITS-1:0] sec,
                                    logic [GATE_COUNT_BITS-1:0] lg);
    req_t rq;
    rq.req_type        = kind;
    rq.time_us         = t;
    rq.second_count    = sec;
    rq.long_gate_count = lg;
    return rq;
  endfunction

  // request of the given kind with every payload bit random
  function automatic req_t scrambled(logic [2:0] kind);
    return make_req(kind, TIME_BITS'({$urandom, $urandom}), SEC_BITS'($urandom),
                    GATE_COUNT_BITS'({$urandom, $urandom}));
  endfunction

  // Lower valid so nothing repeats, then wait for every outstanding response.
  // Sampling at the falling edge keeps clear of the monitor's update.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // One request transaction; random gaps go in front while valid is low.
  task automatic offer_request(req_t rq);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  // Registers change only with the block idle: every response back first.
  task automatic write_settings(logic [31:0] lo, logic [31:0] hi, logic [31:0] lock,
                                logic [31:0] gate, logic [31:0] nom, logic [31:0] late);
    wait_drained();
    write_reg(CFG_WINDOW_LOW, lo);
    write_reg(CFG_WINDOW_HIGH, hi);
    write_reg(CFG_LOCK_PULSES, lock);
    write_reg(CFG_GATE_SEC, gate);
    write_reg(CFG_NOMINAL, nom);
    write_reg(CFG_LATE_LIMIT, late);
    cfg_if.valid <= 1'b0;
    cfg_now.window_low_us  = lo[WIN_BITS-1:0];
    cfg_now.window_high_us = hi[WIN_BITS-1:0];
    cfg_now.lock_pulses    = lock[LOCK_BITS-1:0];
    cfg_now.gate_seconds   = gate[GATE_SEC_BITS-1:0];
    cfg_now.nominal_count  = nom[SEC_BITS-1:0];
    cfg_now.late_limit_us  = late[WIN_BITS-1:0];
  endtask

  // PPS edge one interval after the previous one
  task automatic send_pps(logic [31:0] interval);
    pps_t = pps_t + TIME_BITS'(interval);
    offer_request(make_req(REQ_PPS, pps_t, SEC_BITS'($urandom),
                           GATE_COUNT_BITS'({$urandom, $urandom})));
  endtask

  // settle event some microseconds after the last PPS edge
  task automatic send_settle(logic [31:0] delta, logic [SEC_BITS-1:0] sec,
                             logic [GATE_COUNT_BITS-1:0] lg);
    offer_request(make_req(REQ_SETTLE, pps_t + TIME_BITS'(delta), sec, lg));
  endtask

  // Mostly inside the window; now and then exactly on a bound or outside.
  function automatic logic [31:0] pick_interval();
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    roll = $urandom_range(0, 39);
    lo   = 32'(cfg_now.window_low_us);
    hi   = 32'(cfg_now.window_high_us);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    if (roll == 2) return $urandom_range(0, lo);
    if (roll == 3) return hi + $urandom_range(1, 1000000);
    if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
    return $urandom_range(0, 2000000);
  endfunction

  // Mostly timely, sometimes right on the late limit or just past it.
  function automatic logic [31:0] pick_delta();
    int unsigned roll;
    int unsigned late;
    roll = $urandom_range(0, 24);
    late = 32'(cfg_now.late_limit_us);
    if (roll == 0) return late + $urandom_range(1, 100000);
    if (roll == 1) return late;
    return $urandom_range(0, late);
  endfunction

  // per-second count close to nominal, occasionally anything at all
  function automatic logic [SEC_BITS-1:0] pick_count();
    if ($urandom_range(0, 9) == 0) return SEC_BITS'($urandom);
    return cfg_now.nominal_count + SEC_BITS'($urandom_range(0, 2000)) - SEC_BITS'(1000);
  endfunction

  // One PPS second: an edge followed by usually one settle event,
  // sometimes none or a duplicate that the sequencer must reject.
  task automatic random_second();
    int unsigned roll;
    int          n;
    send_pps(pick_interval());
    roll = $urandom_range(0, 19);
    n    = (roll == 0) ? 0 : ((roll == 1) ? 2 : 1);
    repeat (n) send_settle(pick_delta(), pick_count(), GATE_COUNT_BITS'({$urandom, $urandom}));
  endtask

  task automatic random_item();
    int unsigned roll;
    req_t        rq;
    roll = $urandom_range(0, 99);
    if (roll < 88) begin
      random_second();
    end else if (roll < 90) begin
      offer_request(scrambled(REQ_WDOG));
    end else if (roll < 92) begin
      offer_request(scrambled(REQ_RST_ERR));
    end else if (roll < 93) begin
      offer_request(scrambled(REQ_START));
    end else if (roll < 94) begin
      offer_request(scrambled(3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI))));
    end else begin
      // noise: any code, any payload; a random PPS edge moves the timeline
      rq = scrambled(3'($urandom_range(REQ_PPS, REQ_UNKNOWN_HI)));
      if (rq.req_type == REQ_PPS) pps_t = rq.time_us;
      offer_request(rq);
    end
  endtask

  task automatic run_random(int n);
    int target;
    target = sent_items + n;
    while (sent_items < target) random_item();
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.data   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.idx    <= '0;
    cfg_if.data   <= '0;
    pps_t          = TIME_MAX - TIME_BITS'(2500000);  // timeline wraps during the directed part

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part: sender idles 14%, receiver 69% ----
    write_settings(32'd800000, 32'd1200000, 32'd2, 32'd2, 32'd10000000, 32'd500000);

    send_pps(32'd1000000);                                   // unlocked: counts toward lock
    offer_request(scrambled(REQ_UNKNOWN_HI));                // unknown code: rejected
    send_settle(32'd100000, cfg_now.nominal_count, '0);      // settle in startup: rejected
    send_pps(32'd1000000);
    send_pps(32'd1000000);                                   // locks, but startup rejects pps
    offer_request(scrambled(REQ_WDOG));                      // loss in startup: rejected
    offer_request(scrambled(REQ_WDOG));                      // unlocked watchdog: no effect
    offer_request(scrambled(REQ_START));                     // startup -> wait first pps
    offer_request(scrambled(REQ_START));                     // second start: rejected
    send_pps(32'd1000000);                                   // first edge after loss is good
    send_pps(32'd1000000);
    send_pps(32'd1000000);                                   // lock, wait first -> past first
    send_settle(32'd600000, cfg_now.nominal_count, '0);      // late settle acts as a loss
    send_pps(32'd1000000);                                   // wait before first -> past it
    send_settle(32'd100000, cfg_now.nominal_count, '0);      // clear, wait first pps
    send_pps(32'd1000000);
    send_settle(32'd0, cfg_now.nominal_count, '0);           // clear, arm gate
    send_pps(32'd1000000);
    send_settle(32'd500000, SEC_MAX, '0);                    // per-second report, top count
    send_pps(32'd1000000);
    send_settle(32'd250000, '0, LONG_MAX);                   // last second, zero count
    send_pps(32'd1000000);
    send_settle(32'd1, SEC_MAX, LONG_MAX);                   // long-gate report, max count
    offer_request(scrambled(REQ_RST_ERR));                   // error cleared
    send_pps(32'd100000);                                    // short interval: lock lost
    send_pps(32'd1000000);

    // ---- Random, typical windows, three-second gate ----
    write_settings(32'd900000, 32'd1100000, 32'd3, 32'd3, 32'd10000000, 32'd500000);
    run_random(280);

    // ---- Widest window, instant lock, top nominal and late limit ----
    // Sender idles 69%, receiver 14%; one long response hold-off here.
    send_idle_pct = 69;
    recv_idle_pct = 14;
    write_settings(32'd0, 32'hFF_FFFF, 32'd0, 32'd1, 32'h1FF_FFFF, 32'hFF_FFFF);
    hold_requests++;
    run_random(240);

    // ---- Narrow window, longest lock, gate of zero taken as one,
    //      zero nominal and zero late limit ----
    write_settings(32'd999000, 32'd1001000, 32'd15, 32'd0, 32'd0, 32'd0);
    run_random(200);

    // ---- No idling from here on ----
    // Inverted window: no interval fits, but with zero lock pulses every edge
    // qualifies, as the good count stays zero; longest gate never completes.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(32'hFF_FFFF, 32'd0, 32'd0, 32'hFFFF, 32'd12345678, 32'd1000000);
    run_random(80);

    // Back to typical values. Receiver holds off while requests keep
    // coming, then the sender pauses halfway until everything is back.
    write_settings(32'd800000, 32'd1200000, 32'd1, 32'd2, 32'd10000000, 32'd500000);
    hold_requests++;
    run_random(215);
    wait_drained();
    run_random(215);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
